// ===== rtl/core/iswi_pkg.sv =====
`default_nettype none
package iswi_pkg;
  localparam int CAPACITY_DEF = 32;
  localparam int KEY_W = 32;
  localparam int IDX_W = 5;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
  } entry_t;

  function automatic logic [KEY_W-1:0] order_of(input logic [KEY_W-1:0] bits);
    logic [KEY_W-1:0] b;
    b = (bits == {1'b1, {(KEY_W-1){1'b0}}}) ? '0 : bits;
    order_of = b[KEY_W-1] ? ~b : (b | {1'b1, {(KEY_W-1){1'b0}}});
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/insertion_sort_with_index.sv =====
`default_nettype none
// Systolic insertion sorter. One key is taken per cycle while busy is low;
// every cell compares the new key at once and the chain shifts to make room.
// Up to CAPACITY keys per batch, later ones are dropped and flag overflow.
// After the last key, results leave one per cycle from the head of the chain,
// with busy high meanwhile. out_valid strobes each result for one cycle; the
// receiver cannot stall.
module insertion_sort_with_index
  import iswi_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [KEY_W-1:0] in_key_bits,
  input  wire logic             in_last_item,
  output logic                  out_valid,
  output logic [KEY_W-1:0]      out_sorted_key,
  output logic [IDX_W-1:0]      out_origin_index,
  output logic                  out_final_result,
  output logic                  out_overflow
);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] emit_r, emit_nxt;
  logic          drop_r, drop_nxt;
  logic          drain_r, drain_nxt;
  logic [IDX_W-1:0] arr_r, arr_nxt;
  logic          acc, ins, shift;
  entry_t        new_e;
  entry_t        e [CAPACITY];
  logic          gt [CAPACITY];

  assign acc   = start && !busy;
  assign ins   = acc && (fill_r != CW'(CAPACITY));
  assign shift = drain_r;
  assign busy  = drain_r;
  assign new_e = '{key: in_key_bits, idx: arr_r};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    iswi_cell u_cell (
      .clk      (clk),
      .ins      (ins),
      .shift_out(shift),
      .new_e    (new_e),
      .left_full(i == 0 ? 1'b0 : (CW'(i - 1) < fill_r)),
      .left_e   (i == 0 ? new_e : e[(i == 0) ? 0 : i - 1]),
      .left_gt  (i == 0 ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
      .right_e  (i == CAPACITY - 1 ? e[i] : e[(i == CAPACITY - 1) ? i : i + 1]),
      .pos_full (CW'(i) < fill_r),
      .e_q      (e[i]),
      .gt       (gt[i])
    );
  end

  always_comb begin
    fill_nxt  = fill_r;
    emit_nxt  = emit_r;
    drop_nxt  = drop_r;
    drain_nxt = drain_r;
    arr_nxt   = arr_r;
    if (drain_r) begin
      emit_nxt = emit_r - 1'b1;
      if (emit_r == CW'(1)) begin
        drain_nxt = 1'b0;
        drop_nxt  = 1'b0;
        fill_nxt  = '0;
        arr_nxt   = '0;
      end
    end else if (acc) begin
      if (ins) begin
        fill_nxt = fill_r + 1'b1;
        arr_nxt  = arr_r + 1'b1;
      end else begin
        drop_nxt = 1'b1;
      end
      if (in_last_item) begin
        drain_nxt = 1'b1;
        emit_nxt  = ins ? fill_r + 1'b1 : fill_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      emit_r  <= '0;
      drop_r  <= 1'b0;
      drain_r <= 1'b0;
      arr_r   <= '0;
    end else begin
      fill_r  <= fill_nxt;
      emit_r  <= emit_nxt;
      drop_r  <= drop_nxt;
      drain_r <= drain_nxt;
      arr_r   <= arr_nxt;
    end
  end

  assign out_valid        = drain_r;
  assign out_sorted_key   = e[0].key;
  assign out_origin_index = e[0].idx;
  assign out_final_result = drain_r && (emit_r == CW'(1));
  assign out_overflow     = drop_r;
endmodule
`default_nettype wire

// ===== rtl/core/iswi_cell.sv =====
`default_nettype none
module iswi_cell
  import iswi_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   ins,
  input  wire logic   shift_out,
  input  wire entry_t new_e,
  input  wire logic   left_full,
  input  wire entry_t left_e,
  input  wire logic   left_gt,
  input  wire entry_t right_e,
  input  wire logic   pos_full,
  output entry_t      e_q,
  output logic        gt
);
  entry_t e_r;
  entry_t e_nxt;

  assign gt  = pos_full && (order_of(e_r.key) > order_of(new_e.key));
  assign e_q = e_r;

  always_comb begin
    e_nxt = e_r;
    if (shift_out) begin
      e_nxt = right_e;
    end else if (ins) begin
      if (left_gt && left_full) begin
        e_nxt = left_e;
      end else if (gt || !pos_full) begin
        e_nxt = new_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    e_r <= e_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/core/iswi_checker.sv =====
`default_nettype none
module iswi_checker
  import iswi_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic out_final_result
);
  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_final_result |-> out_valid) else $error("final without valid");
  a_fin_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_final_result |=> !out_valid) else $error("results after final");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");
endmodule

bind insertion_sort_with_index iswi_checker u_chk (
  .clk(clk), .rst_n(rst_n), .busy(busy),
  .out_valid(out_valid), .out_final_result(out_final_result)
);
`default_nettype wire
